// ===== sv/ssfm_pkg.sv =====
// Shared types, constants and helpers for the first-match substring search block.
// Used by every module of the block; no dependencies.
package ssfm_pkg;

  localparam int NEEDLE_MAX_DEF   = 16;
  localparam int HAYSTACK_MAX_DEF = 65536;

  // the needle registers hold at most this many bytes
  localparam int REG_BYTES = 16;
  localparam int LEN_W     = 5;
  localparam int OFFSET_W  = 16;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_GAP     = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEEDLE_LO = 2'd0,
    CFG_NEEDLE_HI = 2'd1,
    CFG_NEEDLE_LEN = 2'd2,
    CFG_MATCH_MODE = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] hay_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
  } out_item_t;

  // configuration as seen by the compare logic
  typedef struct packed {
    logic [REG_BYTES-1:0][7:0] needle;
    logic [LEN_W-1:0]          len;
    logic                      nocase;
  } cfg_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c, input logic nocase);
    logic [7:0] r;
    r = c;
    if (nocase && c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_GAP;
    end
    return r;
  endfunction

endpackage

// ===== sv/ssfm_cfg.sv =====
// Configuration registers of the substring search: needle bytes, length and mode.
// Depends on ssfm_pkg; the length is clamped to the window depth here.
module ssfm_cfg #(
  parameter int NEEDLE_MAX = ssfm_pkg::NEEDLE_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ssfm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ssfm_pkg::CFG_W-1:0]     cfg_wdata_i,
  output ssfm_pkg::cfg_t                 cfg_o
);

  localparam int WinDepth = (NEEDLE_MAX < ssfm_pkg::REG_BYTES) ? NEEDLE_MAX
                                                               : ssfm_pkg::REG_BYTES;
  localparam logic [ssfm_pkg::LEN_W-1:0] LenMax = ssfm_pkg::LEN_W'(WinDepth);

  logic [ssfm_pkg::CFG_W-1:0] needle_lo_q, needle_hi_q;
  logic [ssfm_pkg::LEN_W-1:0] len_q;
  logic                       mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_lo_q <= '0;
      needle_hi_q <= '0;
      len_q       <= ssfm_pkg::LEN_W'(1);
      mode_q      <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (ssfm_pkg::cfg_reg_e'(cfg_idx_i))
        ssfm_pkg::CFG_NEEDLE_LO:  needle_lo_q <= cfg_wdata_i;
        ssfm_pkg::CFG_NEEDLE_HI:  needle_hi_q <= cfg_wdata_i;
        ssfm_pkg::CFG_NEEDLE_LEN: len_q       <= cfg_wdata_i[ssfm_pkg::LEN_W-1:0];
        ssfm_pkg::CFG_MATCH_MODE: mode_q      <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.needle = {needle_hi_q, needle_lo_q};
    cfg_o.len    = (len_q > LenMax) ? LenMax : len_q;
    cfg_o.nocase = mode_q;
  end

endmodule

// ===== sv/ssfm_match.sv =====
// Parallel compare of the shifted byte window against the right-aligned needle.
// Depends on ssfm_pkg for the config struct and the case folding helper.
module ssfm_match #(
  parameter int NEEDLE_MAX = ssfm_pkg::NEEDLE_MAX_DEF
) (
  input  logic [((NEEDLE_MAX < ssfm_pkg::REG_BYTES) ? NEEDLE_MAX
                                                    : ssfm_pkg::REG_BYTES)-1:0][7:0] win_i,
  input  ssfm_pkg::cfg_t cfg_i,
  output logic           same_o
);

  localparam int WinDepth = (NEEDLE_MAX < ssfm_pkg::REG_BYTES) ? NEEDLE_MAX
                                                               : ssfm_pkg::REG_BYTES;

  logic [WinDepth-1:0] eq;

  // window entry 0 is the newest byte and lines up with the last needle byte
  always_comb begin
    for (int k = 0; k < WinDepth; k++) begin
      logic [ssfm_pkg::LEN_W-1:0] nidx;
      logic [ssfm_pkg::LEN_W-1:0] kk;
      kk   = ssfm_pkg::LEN_W'(k);
      nidx = cfg_i.len - ssfm_pkg::LEN_W'(1) - kk;
      if (kk >= cfg_i.len) begin
        eq[k] = 1'b1;
      end else begin
        eq[k] = ssfm_pkg::fold_case(win_i[k], cfg_i.nocase) ==
                ssfm_pkg::fold_case(cfg_i.needle[nidx[3:0]], cfg_i.nocase);
      end
    end
  end

  assign same_o = &eq;

endmodule

// ===== sv/substring_search_first_match.sv =====
// Top level of the first-match substring search: input register, window, counter, result.
// Depends on ssfm_pkg, ssfm_cfg and ssfm_match.
//
//   channel   direction  payload      handshake
//   in        input      in_item_t    in_valid_i / in_stall_o
//   out       output     out_item_t   out_valid_o / out_stall_i
//   cfg       input      64-bit data  cfg_we_i, cfg_idx_i
//
// One byte per cycle sustained while the output is not stalled; a byte goes from the input
// register through the window compare into the result register.
// The window compare and the reported flag are updated in one step, so the byte
// rate is set by that single compare stage.
// Reset clears the counter, flags and configuration; the window needs no clearing.
// An output stall holds the result and backs up into the input register.
module substring_search_first_match #(
  parameter int NEEDLE_MAX   = ssfm_pkg::NEEDLE_MAX_DEF,
  parameter int HAYSTACK_MAX = ssfm_pkg::HAYSTACK_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ssfm_pkg::in_item_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ssfm_pkg::out_item_t            out_data_o,
  input  logic                           cfg_we_i,
  input  logic [ssfm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ssfm_pkg::CFG_W-1:0]     cfg_wdata_i
);

  localparam int WinDepth = (NEEDLE_MAX < ssfm_pkg::REG_BYTES) ? NEEDLE_MAX
                                                               : ssfm_pkg::REG_BYTES;
  localparam int CntW     = $clog2(HAYSTACK_MAX + 1);
  localparam int StartW   = (CntW + 1 > ssfm_pkg::OFFSET_W + 1) ? CntW + 1
                                                                 : ssfm_pkg::OFFSET_W + 1;
  localparam logic [CntW-1:0] CntMax = CntW'(HAYSTACK_MAX);

  ssfm_pkg::cfg_t cfg;

  ssfm_cfg #(
    .NEEDLE_MAX (NEEDLE_MAX)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // input register
  logic               in_valid_q;
  ssfm_pkg::in_item_t in_item_q;
  // stream state
  logic [WinDepth-1:0][7:0] win_q, win_d;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     reported_q, reported_d;
  // result register
  logic                out_valid_q, out_valid_d;
  ssfm_pkg::out_item_t out_item_q, out_item_d;

  logic out_free, advance, same, hit, in_range;
  logic [StartW-1:0] index_ext, len_ext, start;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  assign win_d = {win_q[WinDepth-2:0], in_item_q.hay_byte};

  ssfm_match #(
    .NEEDLE_MAX (NEEDLE_MAX)
  ) u_match (
    .win_i  (win_d),
    .cfg_i  (cfg),
    .same_o (same)
  );

  assign index_ext = StartW'(cnt_q) + StartW'(1);
  assign len_ext   = StartW'(cfg.len);
  assign start     = index_ext - len_ext;
  assign in_range  = (cnt_q != CntMax) && (index_ext >= len_ext);

  always_comb begin
    if (cfg.len == '0) begin
      hit = 1'b1;
    end else begin
      hit = in_range && same && (start[StartW-1:ssfm_pkg::OFFSET_W] == '0);
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    reported_d  = reported_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    if (advance) begin
      if (reported_q) begin
        // bytes after a report are dropped until the last one
        if (in_item_q.last_byte) begin
          cnt_d      = '0;
          reported_d = 1'b0;
        end
      end else begin
        if (cnt_q != CntMax) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (hit) begin
          out_valid_d             = 1'b1;
          out_item_d.found        = 1'b1;
          out_item_d.match_offset = (cfg.len == '0) ? '0 : start[ssfm_pkg::OFFSET_W-1:0];
          reported_d              = !in_item_q.last_byte;
        end else if (in_item_q.last_byte) begin
          out_valid_d             = 1'b1;
          out_item_d.found        = 1'b0;
          out_item_d.match_offset = '0;
        end
        if (in_item_q.last_byte) begin
          cnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      cnt_q       <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      cnt_q       <= cnt_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_data_i;
    end
    if (advance && !reported_q) begin
      win_q <= win_d;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_item_q;

endmodule
